// ----- hdl/lcd_line_timing_registers_unit_macros.svh -----
// ----------------------------------------------------------------------------
// LCD line timing registers - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LCD_LINE_TIMING_REGISTERS_UNIT_MACROS_SVH
`define LCD_LINE_TIMING_REGISTERS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define LLTR_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lltr assertion failed");

// cond at one edge implies expr at the next edge
`define LLTR_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lltr assertion failed");

`else

`define LLTR_ASSERT(lbl, clk, rst_n, expr)
`define LLTR_ASSERT_NEXT(lbl, clk, rst_n, cond, expr)

`endif

`endif

// ----- hdl/lltr_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD line timing registers - package
// Request and result types, opcodes, register addresses and timing constants.
// ----------------------------------------------------------------------------
package lltr_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_request;
    } t_out_item;

    typedef struct packed {
        logic       display_on;
        logic [7:0] line_counter;
        logic [6:0] cycle_in_line;
    } t_timing_status;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [15:0] ADDR_CONTROL      = 16'hFF40;
    localparam logic [15:0] ADDR_STATUS       = 16'hFF41;
    localparam logic [15:0] ADDR_SCROLL_Y     = 16'hFF42;
    localparam logic [15:0] ADDR_SCROLL_X     = 16'hFF43;
    localparam logic [15:0] ADDR_LINE         = 16'hFF44;
    localparam logic [15:0] ADDR_LINE_COMPARE = 16'hFF45;
    localparam logic [15:0] ADDR_BG_PALETTE   = 16'hFF47;
    localparam logic [15:0] ADDR_SPR_PAL0     = 16'hFF48;
    localparam logic [15:0] ADDR_SPR_PAL1     = 16'hFF49;
    localparam logic [15:0] ADDR_WINDOW_Y     = 16'hFF4A;
    localparam logic [15:0] ADDR_WINDOW_X     = 16'hFF4B;

    localparam int CTRL_ENABLE_BIT = 7;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    localparam logic [7:0] VBLANK_LINE   = 8'd144;
    localparam logic [6:0] OAM_END       = 7'd20;
    localparam logic [6:0] XFER_END      = 7'd63;
    localparam logic [7:0] UNMAPPED_DATA = 8'hFF;

endpackage

// ----- hdl/lltr_core.sv -----
// ----------------------------------------------------------------------------
// LCD line timing registers - register file and line timing
// Holds the mapped registers and the scan counters, and works out one request.
// ----------------------------------------------------------------------------
module lltr_core #(
    parameter int CYCLES_PER_LINE = 114,
    parameter int LAST_LINE       = 153
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  lltr_pkg::t_in_item      i_item,
    output lltr_pkg::t_out_item     o_result,
    output lltr_pkg::t_timing_status o_status
);
    import lltr_pkg::*;

    localparam logic [6:0] CYC_LAST  = 7'(CYCLES_PER_LINE - 1);
    localparam logic [7:0] LINE_LAST = 8'(LAST_LINE);

    logic [7:0] r_control, n_control;
    logic [3:0] r_status_sel, n_status_sel;
    logic [7:0] r_scroll_y, n_scroll_y;
    logic [7:0] r_scroll_x, n_scroll_x;
    logic [7:0] r_line, n_line;
    logic [7:0] r_line_cmp, n_line_cmp;
    logic [7:0] r_bg_pal, n_bg_pal;
    logic [7:0] r_spr_pal0, n_spr_pal0;
    logic [7:0] r_spr_pal1, n_spr_pal1;
    logic [7:0] r_win_y, n_win_y;
    logic [7:0] r_win_x, n_win_x;
    logic [6:0] r_cycle, n_cycle;

    logic       w_on;
    logic [1:0] w_mode;
    logic [7:0] w_line_next;
    logic [7:0] w_status;
    logic [7:0] w_rd;

    assign w_on = r_control[CTRL_ENABLE_BIT];
    assign w_line_next = (r_line == LINE_LAST) ? 8'd0 : r_line + 8'd1;

    always_comb begin
        if (!w_on) begin
            w_mode = MODE_HBLANK;
        end else if (r_line >= VBLANK_LINE) begin
            w_mode = MODE_VBLANK;
        end else if (r_cycle < OAM_END) begin
            w_mode = MODE_OAM;
        end else if (r_cycle < XFER_END) begin
            w_mode = MODE_XFER;
        end else begin
            w_mode = MODE_HBLANK;
        end
    end

    assign w_status = {1'b1, r_status_sel, (r_line == r_line_cmp), w_mode};

    always_comb begin
        case (i_item.bus_address)
            ADDR_CONTROL:      w_rd = r_control;
            ADDR_STATUS:       w_rd = w_status;
            ADDR_SCROLL_Y:     w_rd = r_scroll_y;
            ADDR_SCROLL_X:     w_rd = r_scroll_x;
            ADDR_LINE:         w_rd = r_line;
            ADDR_LINE_COMPARE: w_rd = r_line_cmp;
            ADDR_BG_PALETTE:   w_rd = r_bg_pal;
            ADDR_SPR_PAL0:     w_rd = r_spr_pal0;
            ADDR_SPR_PAL1:     w_rd = r_spr_pal1;
            ADDR_WINDOW_Y:     w_rd = r_win_y;
            ADDR_WINDOW_X:     w_rd = r_win_x;
            default:           w_rd = UNMAPPED_DATA;
        endcase
    end

    always_comb begin
        n_control    = r_control;
        n_status_sel = r_status_sel;
        n_scroll_y   = r_scroll_y;
        n_scroll_x   = r_scroll_x;
        n_line       = r_line;
        n_line_cmp   = r_line_cmp;
        n_bg_pal     = r_bg_pal;
        n_spr_pal0   = r_spr_pal0;
        n_spr_pal1   = r_spr_pal1;
        n_win_y      = r_win_y;
        n_win_x      = r_win_x;
        n_cycle      = r_cycle;
        o_result     = '0;
        case (i_item.opcode)
            OP_TICK: begin
                if (w_on) begin
                    if (r_cycle >= CYC_LAST) begin
                        n_cycle = 7'd0;
                        n_line  = w_line_next;
                        o_result.vblank_request = (w_line_next == VBLANK_LINE);
                    end else begin
                        n_cycle = r_cycle + 7'd1;
                    end
                end
            end
            OP_READ: begin
                o_result.read_data = w_rd;
            end
            OP_WRITE: begin
                case (i_item.bus_address)
                    ADDR_CONTROL: begin
                        n_control = i_item.write_data;
                        if (!i_item.write_data[CTRL_ENABLE_BIT]) begin
                            n_line  = 8'd0;
                            n_cycle = 7'd0;
                        end
                    end
                    ADDR_STATUS:       n_status_sel = i_item.write_data[6:3];
                    ADDR_SCROLL_Y:     n_scroll_y   = i_item.write_data;
                    ADDR_SCROLL_X:     n_scroll_x   = i_item.write_data;
                    ADDR_LINE_COMPARE: n_line_cmp   = i_item.write_data;
                    ADDR_BG_PALETTE:   n_bg_pal     = i_item.write_data;
                    ADDR_SPR_PAL0:     n_spr_pal0   = i_item.write_data;
                    ADDR_SPR_PAL1:     n_spr_pal1   = i_item.write_data;
                    ADDR_WINDOW_Y:     n_win_y      = i_item.write_data;
                    ADDR_WINDOW_X:     n_win_x      = i_item.write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= '0;
            r_status_sel <= '0;
            r_scroll_y   <= '0;
            r_scroll_x   <= '0;
            r_line       <= '0;
            r_line_cmp   <= '0;
            r_bg_pal     <= '0;
            r_spr_pal0   <= '0;
            r_spr_pal1   <= '0;
            r_win_y      <= '0;
            r_win_x      <= '0;
            r_cycle      <= '0;
        end else if (i_en) begin
            r_control    <= n_control;
            r_status_sel <= n_status_sel;
            r_scroll_y   <= n_scroll_y;
            r_scroll_x   <= n_scroll_x;
            r_line       <= n_line;
            r_line_cmp   <= n_line_cmp;
            r_bg_pal     <= n_bg_pal;
            r_spr_pal0   <= n_spr_pal0;
            r_spr_pal1   <= n_spr_pal1;
            r_win_y      <= n_win_y;
            r_win_x      <= n_win_x;
            r_cycle      <= n_cycle;
        end
    end

    assign o_status.display_on    = w_on;
    assign o_status.line_counter  = r_line;
    assign o_status.cycle_in_line = r_cycle;

endmodule

// ----- hdl/lcd_line_timing_registers_unit.sv -----
// ----------------------------------------------------------------------------
// LCD line timing registers - top level
// Machine ticks, register reads and register writes in; one result per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output does not stall and returns
// one result per request, in order. A request lands in the input register,
// is resolved against the registers and scan counters by the core, and the
// result is captured in the output register. Throughput is one request per
// cycle, set by that single input-to-result register path; a stalled output
// holds its result and the input register holds the next request behind it.
`include "lcd_line_timing_registers_unit_macros.svh"

module lcd_line_timing_registers_unit #(
    parameter int CYCLES_PER_LINE = 114,
    parameter int LAST_LINE       = 153
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lltr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lltr_pkg::t_out_item o_out_item
);
    import lltr_pkg::*;

    logic           r_in_valid;
    t_in_item       r_in_item;
    logic           r_out_valid;
    t_out_item      r_out_item;
    logic           w_advance;
    t_out_item      w_result;
    t_timing_status w_status;

    assign w_advance  = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    lltr_core #(
        .CYCLES_PER_LINE (CYCLES_PER_LINE),
        .LAST_LINE       (LAST_LINE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_item   (r_in_item),
        .o_result (w_result),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `LLTR_ASSERT(a_cycle_range, i_clk, i_rst_n, w_status.cycle_in_line < 7'(CYCLES_PER_LINE))
    `LLTR_ASSERT(a_line_range, i_clk, i_rst_n, w_status.line_counter <= 8'(LAST_LINE))
    `LLTR_ASSERT(a_off_counters_clear, i_clk, i_rst_n, w_status.display_on || (w_status.line_counter == 8'd0 && w_status.cycle_in_line == 7'd0))
    `LLTR_ASSERT(a_vblank_no_data, i_clk, i_rst_n, !(o_out_valid && o_out_item.vblank_request) || o_out_item.read_data == 8'd0)
    `LLTR_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)

endmodule
